FILE: rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // Width of the internal size and address arithmetic. It covers the
  // largest arena, the largest word count and their sum.
  localparam int CW = 18;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NULL   = 2'd1;
  localparam logic [1:0] ST_NOMEM  = 2'd2;
  localparam logic [1:0] ST_BADREL = 2'd3;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [12:0] HEAP_LIMIT_RESET = 13'd4096;

  typedef struct packed {
    logic        kind;
    logic [15:0] size_bytes;
    logic [11:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [11:0] data_address;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_IDLE, S_START, S_AP, S_AM, S_SPLIT, S_TAKE, S_ADV,
    S_ALOAD, S_G1, S_G2, S_G3, S_RCHK, S_RNX, S_RH, S_FIN
  } state_t;

  typedef enum logic [1:0] {R_P, R_MQN, R_PLN} rd_src_t;

  typedef enum logic [3:0] {
    W_INIT0, W_INIT1, W_MERGE, W_SPLIT, W_TAKE, W_G1, W_G2, W_G3, W_REL
  } wr_sel_t;

  typedef enum logic [1:0] {P_HOLD, P_ZERO, P_PLN, P_MQN} p_op_t;

  typedef struct packed {
    rd_src_t    rd_src;
    logic       wr_en;
    wr_sel_t    wr_sel;
    logic       req_load;
    p_op_t      p_op;
    logic       pl_load;
    logic       pass_set;
    logic       pass_clr;
    logic       top_load;
    logic       res_load;
    logic [1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic size_zero;
    logic is_release;
    logic rel_null;
    logic rel_bad;
    logic mq_busy;
    logic mq_next_gt_p;
    logic pl_next_gt_p;
    logic fit;
    logic split_needed;
    logic p_is_top;
    logic pl_next_zero;
    logic passes;
    logic grow_fail;
    logic p_eq_h;
    logic slot_free;
  } sts_t;

endpackage

FILE: rtl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer that walks the header chain for allocate and release requests.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ffha_pkg::sts_t  sts,
  output ffha_pkg::cmd_t  cmd
);

  ffha_pkg::state_t state, state_next;
  logic [1:0] st, st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffha_pkg::S_INIT0;
      st    <= ffha_pkg::ST_OK;
    end else begin
      state <= state_next;
      st    <= st_next;
    end
  end

  always_comb begin
    state_next = state;
    st_next    = st;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.rd_src = ffha_pkg::R_P;
    cmd.wr_sel = ffha_pkg::W_INIT0;
    cmd.p_op   = ffha_pkg::P_HOLD;
    cmd.res_status = st;
    unique case (state)
      ffha_pkg::S_INIT0: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ffha_pkg::W_INIT0;
        state_next = ffha_pkg::S_INIT1;
      end
      ffha_pkg::S_INIT1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ffha_pkg::W_INIT1;
        state_next = ffha_pkg::S_IDLE;
      end
      ffha_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_next   = ffha_pkg::S_START;
        end
      end
      ffha_pkg::S_START: begin
        if (!sts.is_release) begin
          if (sts.size_zero) begin
            st_next    = ffha_pkg::ST_NULL;
            state_next = ffha_pkg::S_FIN;
          end else begin
            cmd.rd_src = ffha_pkg::R_P;
            state_next = ffha_pkg::S_AP;
          end
        end else if (sts.rel_null) begin
          st_next    = ffha_pkg::ST_NULL;
          state_next = ffha_pkg::S_FIN;
        end else if (sts.rel_bad) begin
          st_next    = ffha_pkg::ST_BADREL;
          state_next = ffha_pkg::S_FIN;
        end else begin
          state_next = ffha_pkg::S_RCHK;
        end
      end
      ffha_pkg::S_AP: begin
        cmd.pl_load = 1'b1;
        if (sts.mq_busy) begin
          state_next = ffha_pkg::S_ADV;
        end else begin
          cmd.rd_src = ffha_pkg::R_MQN;
          state_next = ffha_pkg::S_AM;
        end
      end
      ffha_pkg::S_AM: begin
        if (!sts.mq_busy) begin
          if (!sts.pl_next_gt_p) begin
            st_next    = ffha_pkg::ST_NOMEM;
            state_next = ffha_pkg::S_FIN;
          end else begin
            // Absorb the free neighbor and look at the one after it.
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = ffha_pkg::W_MERGE;
            cmd.pl_load = 1'b1;
            cmd.rd_src  = ffha_pkg::R_MQN;
          end
        end else if (sts.fit) begin
          state_next = sts.split_needed ? ffha_pkg::S_SPLIT : ffha_pkg::S_TAKE;
        end else begin
          state_next = ffha_pkg::S_ADV;
        end
      end
      ffha_pkg::S_SPLIT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ffha_pkg::W_SPLIT;
        state_next = ffha_pkg::S_TAKE;
      end
      ffha_pkg::S_TAKE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ffha_pkg::W_TAKE;
        st_next    = ffha_pkg::ST_OK;
        state_next = ffha_pkg::S_FIN;
      end
      ffha_pkg::S_ADV: begin
        if (sts.pl_next_gt_p) begin
          cmd.p_op   = ffha_pkg::P_PLN;
          cmd.rd_src = ffha_pkg::R_PLN;
          state_next = ffha_pkg::S_AP;
        end else if (!(sts.p_is_top && sts.pl_next_zero)) begin
          st_next    = ffha_pkg::ST_NOMEM;
          state_next = ffha_pkg::S_FIN;
        end else if (!sts.passes) begin
          cmd.pass_set = 1'b1;
          cmd.p_op     = ffha_pkg::P_ZERO;
          state_next   = ffha_pkg::S_ALOAD;
        end else if (sts.grow_fail) begin
          st_next    = ffha_pkg::ST_NOMEM;
          state_next = ffha_pkg::S_FIN;
        end else begin
          cmd.pass_clr = 1'b1;
          state_next   = ffha_pkg::S_G1;
        end
      end
      ffha_pkg::S_ALOAD: begin
        cmd.rd_src = ffha_pkg::R_P;
        state_next = ffha_pkg::S_AP;
      end
      ffha_pkg::S_G1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ffha_pkg::W_G1;
        state_next = ffha_pkg::S_G2;
      end
      ffha_pkg::S_G2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ffha_pkg::W_G2;
        state_next = ffha_pkg::S_G3;
      end
      ffha_pkg::S_G3: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = ffha_pkg::W_G3;
        cmd.top_load = 1'b1;
        cmd.p_op     = ffha_pkg::P_ZERO;
        state_next   = ffha_pkg::S_ALOAD;
      end
      ffha_pkg::S_RCHK: begin
        if (sts.p_eq_h) begin
          cmd.rd_src = ffha_pkg::R_P;
          state_next = ffha_pkg::S_RH;
        end else if (sts.p_is_top) begin
          st_next    = ffha_pkg::ST_BADREL;
          state_next = ffha_pkg::S_FIN;
        end else begin
          cmd.rd_src = ffha_pkg::R_P;
          state_next = ffha_pkg::S_RNX;
        end
      end
      ffha_pkg::S_RNX: begin
        if (!sts.mq_next_gt_p) begin
          st_next    = ffha_pkg::ST_BADREL;
          state_next = ffha_pkg::S_FIN;
        end else begin
          cmd.p_op   = ffha_pkg::P_MQN;
          state_next = ffha_pkg::S_RCHK;
        end
      end
      ffha_pkg::S_RH: begin
        if (sts.mq_busy) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = ffha_pkg::W_REL;
          st_next    = ffha_pkg::ST_OK;
        end else begin
          st_next    = ffha_pkg::ST_BADREL;
        end
        state_next = ffha_pkg::S_FIN;
      end
      ffha_pkg::S_FIN: begin
        if (sts.slot_free) begin
          cmd.res_load = 1'b1;
          state_next   = ffha_pkg::S_IDLE;
        end
      end
      default: state_next = ffha_pkg::S_IDLE;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ffha_pkg::S_IDLE && in_valid) |=> state == ffha_pkg::S_START)
    else $error("accepted request did not start");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> sts.slot_free)
    else $error("result loaded over a pending result");
  a_fin_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ffha_pkg::S_FIN && sts.slot_free) |=> state == ffha_pkg::S_IDLE)
    else $error("finish did not return to idle");

endmodule

FILE: rtl/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp
// Link memory, walk pointers, arena top, limit register and result register.
// ----------------------------------------------------------------------------
module ffha_dp #(
  parameter int HEAP_WORDS = 4096,
  parameter int GROW_WORDS = 17,
  parameter int MIN_BYTES  = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  ffha_pkg::in_item_t  in_data,
  input  logic                cfg_write_en,
  input  logic [12:0]         cfg_write_data,
  input  ffha_pkg::cmd_t      cmd,
  output ffha_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output ffha_pkg::out_item_t out_data
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int LW = AW + 1;
  localparam int CW = ffha_pkg::CW;
  localparam logic [CW-1:0] HEAP_CW = CW'(HEAP_WORDS);
  localparam logic [CW-1:0] GROW_CW = CW'(GROW_WORDS);
  localparam logic [CW-1:0] MIN_CW  = CW'(MIN_BYTES);

  logic [LW-1:0] mem [HEAP_WORDS];
  logic [LW-1:0] mem_q;
  logic [LW-1:0] pl;
  logic [AW-1:0] p, p_next, top, rd_addr, wr_addr;
  logic [LW-1:0] wr_data;
  logic [CW-1:0] nw, nb, take, limit, p_cw, top_cw, pln_cw, mqn_cw, r_cw, h_cw;
  logic [AW-1:0] r, base, last, h, pln, mqn;
  logic          passes;
  logic [12:0]   heap_limit;
  ffha_pkg::in_item_t req;

  assign pln    = pl[LW-1:1];
  assign mqn    = mem_q[LW-1:1];
  assign p_cw   = CW'(p);
  assign top_cw = CW'(top);
  assign pln_cw = CW'(pln);
  assign mqn_cw = CW'(mqn);
  assign r_cw   = p_cw + nw;
  assign r      = AW'(r_cw);
  assign take   = (nw < GROW_CW) ? GROW_CW : nw;
  assign base   = AW'(top_cw + CW'(1));
  assign last   = AW'(top_cw + take);
  assign limit  = (CW'(heap_limit) < HEAP_CW) ? CW'(heap_limit) : HEAP_CW;
  assign h_cw   = CW'(req.release_address) - CW'(1);
  assign h      = AW'(h_cw);
  assign nb     = (CW'(in_data.size_bytes) < MIN_CW) ? MIN_CW : CW'(in_data.size_bytes);

  always_comb begin
    unique case (cmd.rd_src)
      ffha_pkg::R_MQN: rd_addr = mqn;
      ffha_pkg::R_PLN: rd_addr = pln;
      default:         rd_addr = p;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      ffha_pkg::W_INIT0: begin wr_addr = AW'(0); wr_data = {AW'(1), 1'b1}; end
      ffha_pkg::W_INIT1: begin wr_addr = AW'(1); wr_data = {AW'(0), 1'b1}; end
      ffha_pkg::W_MERGE: begin wr_addr = p;      wr_data = mem_q;           end
      ffha_pkg::W_SPLIT: begin wr_addr = r;      wr_data = {pln, 1'b0};     end
      ffha_pkg::W_TAKE:  begin wr_addr = p;      wr_data = {r, 1'b1};       end
      ffha_pkg::W_G1:    begin wr_addr = top;    wr_data = {base, 1'b0};    end
      ffha_pkg::W_G2:    begin wr_addr = base;   wr_data = {last, 1'b0};    end
      ffha_pkg::W_G3:    begin wr_addr = last;   wr_data = {AW'(0), 1'b1};  end
      ffha_pkg::W_REL:   begin wr_addr = h;      wr_data = {mqn, 1'b0};     end
      default:           begin wr_addr = p;      wr_data = mem_q;           end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_comb begin
    unique case (cmd.p_op)
      ffha_pkg::P_ZERO: p_next = '0;
      ffha_pkg::P_PLN:  p_next = pln;
      ffha_pkg::P_MQN:  p_next = mqn;
      default:          p_next = p;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top        <= AW'(1);
      heap_limit <= ffha_pkg::HEAP_LIMIT_RESET;
      out_valid  <= 1'b0;
      passes     <= 1'b0;
    end else begin
      if (cfg_write_en) heap_limit <= cfg_write_data;
      if (cmd.top_load) top <= last;
      if (cmd.req_load || cmd.pass_clr) passes <= 1'b0;
      else if (cmd.pass_set) passes <= 1'b1;
      if (cmd.res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req <= in_data;
      nw  <= (nb + CW'(3)) >> 1;
      p   <= '0;
    end else begin
      p <= p_next;
    end
    if (cmd.pl_load) pl <= mem_q;
    if (cmd.res_load) begin
      out_data.status <= cmd.res_status;
      out_data.data_address <= (cmd.res_status == ffha_pkg::ST_OK &&
                                req.kind == ffha_pkg::KIND_ALLOC) ?
                               12'(p_cw + CW'(1)) : 12'd0;
    end
  end

  always_comb begin
    sts.size_zero    = (req.size_bytes == 16'd0);
    sts.is_release   = (req.kind == ffha_pkg::KIND_RELEASE);
    sts.rel_null     = (req.release_address == 12'd0);
    sts.rel_bad      = (h_cw == CW'(0)) || (h_cw == top_cw) || (h_cw >= HEAP_CW);
    sts.mq_busy      = mem_q[0];
    sts.mq_next_gt_p = (mqn > p);
    sts.pl_next_gt_p = (pln > p);
    sts.fit          = (pln_cw >= r_cw);
    sts.split_needed = (pln_cw > r_cw);
    sts.p_is_top     = (p == top);
    sts.pl_next_zero = (pln == '0);
    sts.passes       = passes;
    sts.grow_fail    = (top_cw + CW'(1) + take > limit);
    sts.p_eq_h       = (p_cw == h_cw);
    sts.slot_free    = !out_valid || out_ready;
  end

  a_top_nonzero: assert property (@(posedge clk) disable iff (rst) top != '0)
    else $error("arena top reached header zero");
  a_top_grows: assert property (@(posedge clk) disable iff (rst)
    !rst |=> top >= $past(top))
    else $error("arena top moved down");
  a_top_in_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.top_load |-> (top_cw + take < limit + CW'(1)))
    else $error("arena grew past the limit");

endmodule

FILE: rtl/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator with free-block coalescing over a word-addressed arena.
// ----------------------------------------------------------------------------
// Usage: a request transaction on the in channel (in_valid/in_ready, in_data)
// either allocates size_bytes or releases release_address. Each request
// yields exactly one result transaction on the out channel (out_valid,
// out_ready, out_data) carrying data_address and status.
// Requests are handled one at a time. An allocate makes one registered read
// of the link memory per header visited on the chain, with one more read and
// header write per merged free neighbor, plus three header writes when the
// arena top grows; a release makes one registered read per header from the
// arena start to the target. Trivial cases go from the start state straight
// to the finish state.
// The result sits in an output register, so a new request is accepted as
// soon as the sequencer is idle, even if the previous result is still
// waiting; if the receiver stalls long enough for the next result to be
// ready, the sequencer holds in its finish state until the slot drains.
// After reset the block writes the two initial headers into the link memory
// before it raises in_ready; the rest of the memory is never read before it
// is written. heap_limit resets to 4096 and is written with cfg_write_en/
// cfg_write_data; the user must write it only while idle (it is unchecked).
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core #(
  parameter int HEAP_WORDS = 4096,
  parameter int GROW_WORDS = 17,
  parameter int MIN_BYTES  = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffha_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffha_pkg::out_item_t out_data,
  input  logic                cfg_write_en,
  input  logic [12:0]         cfg_write_data
);

  // Command and status buses between the sequencer and the datapath.
  ffha_pkg::cmd_t cmd;
  ffha_pkg::sts_t sts;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the link memory, the walk pointer, the arena top and
  // the result register.
  ffha_dp #(
    .HEAP_WORDS (HEAP_WORDS),
    .GROW_WORDS (GROW_WORDS),
    .MIN_BYTES  (MIN_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .in_data        (in_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

FILE: verif/tb_first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_core
// Self-checking testbench for the first-fit heap allocator core. A model of
// the header chain, the arena top and the heap limit predicts the result of
// every accepted request. A checker process compares each result transaction
// with the oldest prediction. Directed cases come first, then limit sweeps, a
// backpressure phase, a long random phase and a final phase with no idling.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_core;

  localparam int ARENA_WORDS = 4096;
  localparam int GROW_MIN    = 17;
  localparam int MIN_REQ     = 14;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ffha_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ffha_pkg::out_item_t out_data;
  logic        cfg_write_en = 1'b0;
  logic [12:0] cfg_write_data = '0;

  always #6 clk = ~clk;

  first_fit_heap_allocator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
  );

  // Model state: each header word holds (next << 1) | busy.
  logic [12:0] hdr_links [ARENA_WORDS];
  int unsigned arena_top_m;
  int unsigned heap_limit_m;

  ffha_pkg::out_item_t pending_results [$];
  logic [11:0] live_blocks [$];
  int          error_count = 0;
  bit          quiet = 1'b0;        // No idling on either side when set.
  bit          pressure_req = 1'b0;

  function automatic int unsigned next_of(int unsigned i);
    if (i >= ARENA_WORDS) return 0;
    return hdr_links[i] >> 1;
  endfunction

  function automatic bit busy_of(int unsigned i);
    if (i >= ARENA_WORDS) return 1'b1;
    return hdr_links[i][0];
  endfunction

  function automatic void set_hdr(int unsigned i, int unsigned nxt, bit b);
    if (i < ARENA_WORDS) hdr_links[i] = {nxt[11:0], b};
  endfunction

  function automatic void reset_heap_model();
    foreach (hdr_links[i]) hdr_links[i] = '0;
    set_hdr(0, 1, 1'b1);
    set_hdr(1, 0, 1'b1);
    arena_top_m  = 1;
    heap_limit_m = ffha_pkg::HEAP_LIMIT_RESET;
  endfunction

  // First-fit scan from header 0 that merges free runs on the way and grows
  // the top after two full passes found nothing.
  function automatic logic [1:0] alloc_result(int unsigned nbytes,
                                              output logic [11:0] addr);
    int unsigned nw, p, q, r, passes, take, base, last, lim, guard;
    addr = '0;
    passes = 0;
    guard = 0;
    if (nbytes == 0) return ffha_pkg::ST_NULL;
    if (nbytes < MIN_REQ) nbytes = MIN_REQ;
    nw  = (nbytes + 3) / 2;
    lim = (heap_limit_m < ARENA_WORDS) ? heap_limit_m : ARENA_WORDS;
    p = 0;
    forever begin
      guard++;
      if (guard > 8 * ARENA_WORDS + 64) return ffha_pkg::ST_NOMEM;
      if (!busy_of(p)) begin
        while (!busy_of(next_of(p))) begin
          q = next_of(p);
          if (q <= p) return ffha_pkg::ST_NOMEM;
          hdr_links[p] = hdr_links[q];
        end
        q = next_of(p);
        if (q >= p + nw) begin
          r = p + nw;
          if (q > r) set_hdr(r, q, 1'b0);
          set_hdr(p, r, 1'b1);
          addr = 12'(p + 1);
          return ffha_pkg::ST_OK;
        end
      end
      q = p;
      p = next_of(q);
      if (p > q) continue;
      if (q != arena_top_m || p != 0) return ffha_pkg::ST_NOMEM;
      passes++;
      if (passes <= 1) continue;
      passes = 0;
      take = (nw < GROW_MIN) ? GROW_MIN : nw;
      base = arena_top_m + 1;
      if (base + take > lim) return ffha_pkg::ST_NOMEM;
      last = base + take - 1;
      set_hdr(arena_top_m, base, 1'b0);
      set_hdr(base, last, 1'b0);
      arena_top_m = last;
      set_hdr(last, 0, 1'b1);
    end
  endfunction

  function automatic logic [1:0] release_result(logic [11:0] addr);
    int unsigned h, p, n;
    if (addr == 0) return ffha_pkg::ST_NULL;
    h = addr - 1;
    if (h == 0 || h == arena_top_m) return ffha_pkg::ST_BADREL;
    p = 0;
    while (p != h) begin
      if (p == arena_top_m) return ffha_pkg::ST_BADREL;
      n = next_of(p);
      if (n <= p) return ffha_pkg::ST_BADREL;
      p = n;
    end
    if (!busy_of(h)) return ffha_pkg::ST_BADREL;
    hdr_links[h][0] = 1'b0;
    return ffha_pkg::ST_OK;
  endfunction

  // Offer one request and hold it until accepted, then predict its result.
  task automatic send_request(ffha_pkg::in_item_t req);
    ffha_pkg::out_item_t res;
    int idx [$];
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req.kind == ffha_pkg::KIND_ALLOC) begin
      res.status = alloc_result(req.size_bytes, res.data_address);
      if (res.status == ffha_pkg::ST_OK) live_blocks.push_back(res.data_address);
    end else begin
      res.data_address = '0;
      res.status = release_result(req.release_address);
      if (res.status == ffha_pkg::ST_OK) begin
        idx = live_blocks.find_first_index(x) with (x == req.release_address);
        if (idx.size() != 0) live_blocks.delete(idx[0]);
      end
    end
    pending_results.push_back(res);
  endtask

  task automatic do_alloc(int unsigned nbytes);
    ffha_pkg::in_item_t r;
    r.kind = ffha_pkg::KIND_ALLOC;
    r.size_bytes = nbytes[15:0];
    r.release_address = 12'($urandom);
    send_request(r);
  endtask

  task automatic do_release(logic [11:0] addr);
    ffha_pkg::in_item_t r;
    r.kind = ffha_pkg::KIND_RELEASE;
    r.size_bytes = 16'($urandom);
    r.release_address = addr;
    send_request(r);
  endtask

  // Drain every outstanding result, then write the limit while idle.
  task automatic set_heap_limit(logic [12:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    heap_limit_m = value;
  endtask

  function automatic int unsigned pick_size();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(1, 64);
    if (sel < 95) return $urandom_range(65, 600);
    return $urandom_range(0, 65535);
  endfunction

  // One random request: mostly well-formed alloc/release traffic, the rest
  // noise such as stray addresses and double releases.
  task automatic random_request();
    int unsigned sel, k;
    ffha_pkg::in_item_t r;
    sel = $urandom_range(99);
    if (sel < 80) begin
      if (live_blocks.size() != 0 && $urandom_range(99) < 45) begin
        k = $urandom_range(live_blocks.size() - 1);
        do_release(live_blocks[k]);
      end else begin
        do_alloc(pick_size());
      end
    end else if (sel < 90) begin
      r = ffha_pkg::in_item_t'($urandom);
      send_request(r);
    end else begin
      // Release a live block, or the address just past it: a stray word.
      if (live_blocks.size() != 0)
        do_release(live_blocks[$urandom_range(live_blocks.size() - 1)] +
                   12'($urandom_range(1)));
      else
        do_release(12'($urandom));
    end
  endtask

  task automatic test_directed();
    logic [11:0] a;
    do_alloc(0);                 // zero bytes gives a null result
    do_release(12'd0);           // null release
    do_release(12'd1);           // header 0 can never be released
    do_release(12'd2);           // the top itself
    do_alloc(1);
    a = live_blocks[$];
    do_alloc(13);
    do_alloc(14);
    do_alloc(15);
    do_alloc(65535);             // far beyond any arena
    do_release(a);
    do_release(a);               // already free
    do_release(a + 12'd1);       // not a header
    do_release(12'hFFF);
    do_alloc(40);                // larger than the freed slot
    do_alloc(10);                // fits the freed slot
    do_release(live_blocks[1]);
    do_release(live_blocks[1]);
    do_alloc(30);                // merges the two adjacent free blocks
    do_alloc(32768);
    do_alloc(16'h5555);
    do_release(12'hAAA);
    do_release(12'h555);
  endtask

  task automatic test_limits();
    set_heap_limit(13'd4);       // below the current top
    do_alloc(20);
    do_alloc(1);
    set_heap_limit(13'h1FFF);    // clipped to the arena size
    repeat (30) random_request();
    set_heap_limit(13'd150);
    repeat (60) random_request();
    set_heap_limit(13'd1000);
    repeat (60) random_request();
    set_heap_limit(13'd4096);
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    pressure_req <= 1'b1;
    @(posedge clk);
    pressure_req <= 1'b0;
    repeat (30) do_alloc($urandom_range(1, 40));
  endtask

  task automatic test_random();
    repeat (450) random_request();
    set_heap_limit(13'd600);
    repeat (250) random_request();
    set_heap_limit(13'd4096);
    repeat (200) random_request();
  endtask

  task automatic test_tail();
    quiet = 1'b1;
    repeat (100) random_request();
  endtask

  // Receiver side: random short stalls plus one long hold on request.
  always @(posedge clk) begin
    int stall_left;
    if (pressure_req) begin
      stall_left = 400;
    end else if (stall_left == 0 && !quiet && $urandom_range(4) == 0) begin
      stall_left = $urandom_range(1, 5);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: every result must match the oldest prediction.
  always @(posedge clk) begin
    ffha_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: addr=%0d status=%0d",
                   out_data.data_address, out_data.status);
      end else begin
        want = pending_results.pop_front();
        if (out_data.data_address !== want.data_address ||
            out_data.status !== want.status) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                     want.data_address, want.status,
                     out_data.data_address, out_data.status);
        end
      end
    end
  end

  initial begin
    reset_heap_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_limits();
    test_backpressure();
    test_random();
    test_tail();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0)
      $display("tb_first_fit_heap_allocator_core: done, clean");
    else
      $display("tb_first_fit_heap_allocator_core: done, errors");
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #300000000;
    $display("tb_first_fit_heap_allocator_core: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ffha_pkg.sv
rtl/ffha_ctrl.sv
rtl/ffha_dp.sv
rtl/first_fit_heap_allocator_core.sv
verif/tb_first_fit_heap_allocator_core.sv
